/* hdl/tpc_pkg.sv */
// Shared types and constants of the temperature and pressure compensation block.
// Used by every module under hdl; depends on nothing else.
package tpc_pkg;

    localparam int CAL_W     = 48;
    localparam int DIV_STEPS = 64;

    localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] REG_PRES_LOW  = 2'd1;
    localparam logic [1:0] REG_PRES_MID  = 2'd2;
    localparam logic [1:0] REG_PRES_HIGH = 2'd3;

    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic signed [63:0] PRES_SCALE  = 64'sd3125;
    localparam logic [20:0]        PRES_BASE   = 21'd1048576;
    localparam logic signed [63:0] PRES_BIAS   = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure;
        logic               divide_by_zero;
    } out_t;

    typedef struct packed {
        logic [CAL_W-1:0] temp_cal;
        logic [CAL_W-1:0] pres_low;
        logic [CAL_W-1:0] pres_mid;
        logic [CAL_W-1:0] pres_high;
    } cal_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] fine_temperature;
        logic signed [63:0] numerator;
        logic signed [63:0] denominator;
    } mid_t;

endpackage

/* hdl/tpc_regs.sv */
// Calibration register file behind the APB-style configuration port.
// Depends on tpc_pkg for the calibration struct and register indexes.
module tpc_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output tpc_pkg::cal_t cal
);
    import tpc_pkg::*;

    logic [CAL_W-1:0] temp_cal_reg;
    logic [CAL_W-1:0] pres_low_reg;
    logic [CAL_W-1:0] pres_mid_reg;
    logic [CAL_W-1:0] pres_high_reg;
    logic [1:0]       index;
    logic             wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:3];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg  <= '0;
            pres_low_reg  <= '0;
            pres_mid_reg  <= '0;
            pres_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_TEMP_CAL:  temp_cal_reg  <= pwdata[CAL_W-1:0];
                REG_PRES_LOW:  pres_low_reg  <= pwdata[CAL_W-1:0];
                REG_PRES_MID:  pres_mid_reg  <= pwdata[CAL_W-1:0];
                REG_PRES_HIGH: pres_high_reg <= pwdata[CAL_W-1:0];
                default:       temp_cal_reg  <= temp_cal_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_TEMP_CAL:  prdata = {{(64-CAL_W){1'b0}}, temp_cal_reg};
            REG_PRES_LOW:  prdata = {{(64-CAL_W){1'b0}}, pres_low_reg};
            REG_PRES_MID:  prdata = {{(64-CAL_W){1'b0}}, pres_mid_reg};
            REG_PRES_HIGH: prdata = {{(64-CAL_W){1'b0}}, pres_high_reg};
            default:       prdata = '0;
        endcase
    end

    assign cal.temp_cal  = temp_cal_reg;
    assign cal.pres_low  = pres_low_reg;
    assign cal.pres_mid  = pres_mid_reg;
    assign cal.pres_high = pres_high_reg;

endmodule

/* hdl/tpc_front.sv */
// Front pipeline: temperature compensation and the pressure dividend and divisor.
// Depends on tpc_pkg for the beat and calibration types.
module tpc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tpc_pkg::in_t  in_data,
    input  tpc_pkg::cal_t cal,
    output logic          mid_valid,
    input  logic          mid_ready,
    output tpc_pkg::mid_t mid_data
);
    import tpc_pkg::*;

    localparam int STAGES = 10;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              en;

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6;
    logic signed [16:0] p1s;
    logic signed [63:0] p4w;

    logic [20:0]        praw_reg [0:7];
    logic signed [31:0] fine_reg [3:9];
    logic signed [31:0] temp_reg [4:9];

    logic signed [31:0] a_reg, b_reg, m1_reg, bb_reg, tv1_reg, m2_reg;
    logic signed [32:0] v1_reg;
    logic signed [63:0] sq_reg, v1p5_reg, v1p2_reg;
    logic signed [63:0] v2a_reg, v1a_reg, v1p5d_reg, v1p2d_reg;
    logic signed [63:0] v2_reg, v1b_reg, v1c_reg, num0_reg;
    logic signed [63:0] num_reg, den_reg;
    logic signed [63:0] praw_w;

    assign t1  = cal.temp_cal[15:0];
    assign t2  = cal.temp_cal[31:16];
    assign t3  = cal.temp_cal[47:32];
    assign p1  = cal.pres_low[15:0];
    assign p2  = cal.pres_low[31:16];
    assign p3  = cal.pres_low[47:32];
    assign p4  = cal.pres_mid[15:0];
    assign p5  = cal.pres_mid[31:16];
    assign p6  = cal.pres_mid[47:32];
    assign p1s = {1'b0, p1};
    assign p4w = 64'(p4);
    assign praw_w = {43'd0, praw_reg[7]};

    assign en         = !valid_reg[STAGES-1] || mid_ready;
    assign in_ready   = en;
    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k < 8; k++)
            begin
                praw_reg[k] <= praw_reg[k-1];
            end
            for (int k = 4; k < 10; k++)
            begin
                fine_reg[k] <= fine_reg[k-1];
            end
            for (int k = 5; k < 10; k++)
            begin
                temp_reg[k] <= temp_reg[k-1];
            end

            a_reg       <= 32'(in_data.raw_temperature >> 3) - 32'({t1, 1'b0});
            b_reg       <= 32'(in_data.raw_temperature >> 4) - 32'(t1);
            praw_reg[0] <= PRES_BASE - 21'(in_data.raw_pressure);

            m1_reg <= a_reg * t2;
            bb_reg <= b_reg * b_reg;

            tv1_reg <= m1_reg >>> 11;
            m2_reg  <= (bb_reg >>> 12) * t3;

            fine_reg[3] <= tv1_reg + (m2_reg >>> 14);

            temp_reg[4] <= (fine_reg[3] * 32'sd5 + 32'sd128) >>> 8;
            v1_reg      <= {fine_reg[3][31], fine_reg[3]} - FINE_OFFSET;

            sq_reg   <= v1_reg * v1_reg;
            v1p5_reg <= v1_reg * p5;
            v1p2_reg <= v1_reg * p2;

            v2a_reg   <= sq_reg * p6;
            v1a_reg   <= sq_reg * p3;
            v1p5d_reg <= v1p5_reg;
            v1p2d_reg <= v1p2_reg;

            v2_reg  <= v2a_reg + (v1p5d_reg <<< 17) + (p4w <<< 35);
            v1b_reg <= (v1a_reg >>> 8) + (v1p2d_reg <<< 12);

            v1c_reg  <= (PRES_BIAS + v1b_reg) * p1s;
            num0_reg <= (praw_w <<< 31) - v2_reg;

            den_reg <= v1c_reg >>> 33;
            num_reg <= num0_reg * PRES_SCALE;
        end
    end

    assign mid_valid                 = valid_reg[STAGES-1];
    assign mid_data.temperature      = temp_reg[9];
    assign mid_data.fine_temperature = fine_reg[9];
    assign mid_data.numerator        = num_reg;
    assign mid_data.denominator      = den_reg;

endmodule

/* hdl/tpc_fifo.sv */
// Short queue that decouples the front pipeline from the divider pipeline.
// Depends on tpc_pkg for the intermediate beat type.
module tpc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tpc_pkg::mid_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tpc_pkg::mid_t pop_data
);
    import tpc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mid_t          mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on a lone push");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds its depth");

endmodule

/* hdl/tpc_back.sv */
// Back pipeline: restoring signed divider, one quotient bit per stage, then the
// pressure correction terms and the output register. Depends on tpc_pkg.
module tpc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mid_valid,
    output logic          mid_ready,
    input  tpc_pkg::mid_t mid_data,
    input  tpc_pkg::cal_t cal,
    output logic          out_valid,
    input  logic          out_ready,
    output tpc_pkg::out_t out_data
);
    import tpc_pkg::*;

    localparam int NB = DIV_STEPS + 6;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] fine_temperature;
        logic               neg;
        logic               dz;
    } side_t;

    logic [NB-1:0]      valid_reg;
    logic [NB-1:0]      valid_next;
    logic               en;
    side_t              side_reg [0:NB-2];
    logic [63:0]        rem_reg [0:DIV_STEPS];
    logic [63:0]        q_reg [0:DIV_STEPS];
    logic [63:0]        ub_reg [0:DIV_STEPS-1];
    logic signed [63:0] p_reg [0:3];
    logic signed [63:0] m8_reg [0:1];
    logic signed [63:0] ph_reg, x_reg, w1_reg, w2_reg;
    logic [63:0]        ll_reg, xs;
    logic [31:0]        lh_reg, hl_reg;
    logic [39:0]        sum40;
    logic [31:0]        pres;
    logic signed [15:0] p7, p8, p9;
    logic signed [31:0] p7w;
    logic signed [63:0] num, den;
    out_t               out_reg;

    assign p7  = cal.pres_high[15:0];
    assign p8  = cal.pres_high[31:16];
    assign p9  = cal.pres_high[47:32];
    assign p7w = 32'(p7);
    assign num = mid_data.numerator;
    assign den = mid_data.denominator;

    assign en         = !valid_reg[NB-1] || out_ready;
    assign mid_ready  = en;
    assign valid_next = {valid_reg[NB-2:0], mid_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign xs    = ll_reg + {lh_reg + hl_reg, 32'd0};
    assign sum40 = p_reg[3][39:0] + w1_reg[39:0] + w2_reg[39:0];
    assign pres  = sum40[39:8] + {p7w[27:0], 4'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k < NB - 1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            side_reg[0].temperature      <= mid_data.temperature;
            side_reg[0].fine_temperature <= mid_data.fine_temperature;
            side_reg[0].neg              <= num[63] ^ den[63];
            side_reg[0].dz               <= den == '0;

            rem_reg[0] <= '0;
            q_reg[0]   <= num[63] ? 64'd0 - num : num;
            ub_reg[0]  <= den[63] ? 64'd0 - den : den;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                if ({rem_reg[k-1], q_reg[k-1][63]} >= {1'b0, ub_reg[k-1]})
                begin
                    rem_reg[k] <= 64'({rem_reg[k-1], q_reg[k-1][63]} - {1'b0, ub_reg[k-1]});
                    q_reg[k]   <= {q_reg[k-1][62:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= {rem_reg[k-1][62:0], q_reg[k-1][63]};
                    q_reg[k]   <= {q_reg[k-1][62:0], 1'b0};
                end
            end
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                ub_reg[k] <= ub_reg[k-1];
            end

            p_reg[0] <= side_reg[DIV_STEPS].neg ? 64'd0 - q_reg[DIV_STEPS]
                                                : q_reg[DIV_STEPS];
            for (int k = 1; k < 4; k++)
            begin
                p_reg[k] <= p_reg[k-1];
            end

            ph_reg    <= p_reg[0] >>> 13;
            x_reg     <= p9 * (p_reg[0] >>> 13);
            m8_reg[0] <= p8 * p_reg[0];
            m8_reg[1] <= m8_reg[0];

            ll_reg <= x_reg[31:0] * ph_reg[31:0];
            lh_reg <= x_reg[63:32] * ph_reg[31:0];
            hl_reg <= x_reg[31:0] * ph_reg[63:32];

            w1_reg <= $signed(xs) >>> 25;
            w2_reg <= m8_reg[1] >>> 19;

            out_reg.temperature      <= side_reg[NB-2].temperature;
            out_reg.fine_temperature <= side_reg[NB-2].fine_temperature;
            out_reg.divide_by_zero   <= side_reg[NB-2].dz;
            out_reg.pressure         <= side_reg[NB-2].dz ? '0 : pres;
        end
    end

    assign out_valid = valid_reg[NB-1];
    assign out_data  = out_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_by_zero |-> out_data.pressure == '0)
        else $error("pressure not forced to zero on a zero divisor");
    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !side_reg[0].dz |-> ub_reg[0] != '0)
        else $error("nonzero divisor lost its magnitude");

endmodule

/* hdl/temp_pressure_compensation.sv */
// Top level of the temperature and pressure compensation block.
// Depends on tpc_pkg, tpc_regs, tpc_front, tpc_fifo and tpc_back.
//
//  channel  | handshake          | beat
//  ---------+--------------------+---------------------------------------
//  in       | in_valid/in_ready  | in_data: raw temperature and pressure
//  out      | out_valid/out_ready| out_data: temperature, fine, pressure
//  config   | psel/penable/pready| four 48-bit calibration registers
//
// One beat is accepted per cycle while out_ready stays high. Before out_valid rises,
// a beat passes 81 registers: 10 front stages, one queue entry and 70 back stages
// (64 divider steps and 6 for input, correction and output). While out_ready is high,
// throughput is one beat per cycle, since the divider is fully pipelined.
// Reset clears all calibration registers and empties every pipeline stage.
// A stalled output freezes the back pipeline; the queue lets the front keep
// working until it fills.
module temp_pressure_compensation #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tpc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tpc_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import tpc_pkg::*;

    cal_t cal;
    logic f_valid, f_ready, b_valid, b_ready;
    mid_t f_data, b_data;

    tpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    tpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cal       (cal),
        .mid_valid (f_valid),
        .mid_ready (f_ready),
        .mid_data  (f_data)
    );

    tpc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    tpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (b_valid),
        .mid_ready (b_ready),
        .mid_data  (b_data),
        .cal       (cal),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* tb/temp_pressure_compensation_tb.sv */
// Self-checking testbench for temp_pressure_compensation: random and directed raw
// sample pairs under several calibration settings and handshake idling phases.
// Depends on tpc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module temp_pressure_compensation_tb;
    import tpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [47:0] CAL_MASK = 48'hFFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    logic [47:0] cal_temp;
    logic [47:0] cal_low;
    logic [47:0] cal_mid;
    logic [47:0] cal_high;

    in_t  sample_queue[$];
    out_t expected_results[$];
    int   send_idle;
    int   recv_stall;
    int   mismatches;
    int   beats_in;
    int   beats_out;
    int   zero_divisor_seen;
    int   quiet_cycles;
    bit   running;

    temp_pressure_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    function automatic logic signed [63:0] field64(logic [47:0] r, int pos);
        logic [15:0] v;
        v = r[pos +: 16];
        return {{48{v[15]}}, v};
    endfunction

    function automatic out_t compensate(in_t s);
        logic signed [31:0] adc_t;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] tv1;
        logic signed [31:0] tv2;
        logic signed [31:0] fine;
        logic signed [31:0] bb;
        logic signed [63:0] p1;
        logic signed [63:0] f;
        logic signed [63:0] v1;
        logic signed [63:0] v2;
        logic signed [63:0] num;
        logic signed [63:0] p;
        logic signed [63:0] ph;
        logic signed [63:0] w1;
        logic signed [63:0] w2;
        logic [63:0]        ua;
        logic [63:0]        ub;
        logic [63:0]        q;
        out_t r;
        adc_t = {12'd0, s.raw_temperature};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        a = (adc_t >>> 3) - (t1 <<< 1);
        tv1 = (a * t2) >>> 11;
        b = (adc_t >>> 4) - t1;
        bb = (b * b) >>> 12;
        tv2 = (bb * t3) >>> 14;
        fine = tv1 + tv2;
        r.temperature = (fine * 32'sd5 + 32'sd128) >>> 8;
        r.fine_temperature = fine;
        p1 = {48'd0, cal_low[15:0]};
        f = {{32{fine[31]}}, fine};
        v1 = f - 64'sd128000;
        v2 = v1 * v1 * field64(cal_mid, 32);
        v2 = v2 + ((v1 * field64(cal_mid, 16)) <<< 17);
        v2 = v2 + (field64(cal_mid, 0) <<< 35);
        v1 = ((v1 * v1 * field64(cal_low, 32)) >>> 8) + ((v1 * field64(cal_low, 16)) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.pressure = '0;
        r.divide_by_zero = 1'b0;
        if (v1 == 0)
        begin
            r.divide_by_zero = 1'b1;
        end
        else
        begin
            p = 64'sd1048576 - {44'd0, s.raw_pressure};
            num = ((p <<< 31) - v2) * 64'sd3125;
            ua = num[63] ? -num : num;
            ub = v1[63] ? -v1 : v1;
            q = ua / ub;
            p = (num[63] != v1[63]) ? -q : q;
            ph = p >>> 13;
            w1 = (field64(cal_high, 32) * ph * ph) >>> 25;
            w2 = (field64(cal_high, 16) * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (field64(cal_high, 0) <<< 4);
            r.pressure = p[31:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(compensate(in_data));
                beats_in <= beats_in + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_data <= sample_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_out <= beats_out + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Unexpected output beat: %p", out_data);
                end
                else
                begin
                    if (out_data.divide_by_zero)
                        zero_divisor_seen <= zero_divisor_seen + 1;
                    if (out_data !== expected_results[0])
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, got %p",
                                     expected_results[0], out_data);
                    end
                    void'(expected_results.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (running)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout with %0d results outstanding", expected_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_cal(logic [1:0] idx, logic [47:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP_CAL: cal_temp = value;
            REG_PRES_LOW: cal_low = value;
            REG_PRES_MID: cal_mid = value;
            default: cal_high = value;
        endcase
    endtask

    task automatic load_cal(logic [47:0] t, logic [47:0] lo, logic [47:0] mi, logic [47:0] hi);
        write_cal(REG_TEMP_CAL, t);
        write_cal(REG_PRES_LOW, lo);
        write_cal(REG_PRES_MID, mi);
        write_cal(REG_PRES_HIGH, hi);
    endtask

    task automatic drain();
        while (sample_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic add_sample(logic [19:0] rt, logic [19:0] rp);
        in_t s;
        s.raw_temperature = rt;
        s.raw_pressure = rp;
        sample_queue.push_back(s);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0:
            begin
                send_idle = 0;
                recv_stall = 0;
            end
            1:
            begin
                send_idle = 68;
                recv_stall = 0;
            end
            2:
            begin
                send_idle = 0;
                recv_stall = 68;
            end
            default:
            begin
                send_idle = 32;
                recv_stall = 32;
            end
        endcase
    endtask

    function automatic logic [47:0] random_cal();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] near_typical(logic [47:0] base);
        logic [47:0] r;
        r = base;
        for (int k = 0; k < 3; k++)
            r[k*16 +: 16] = base[k*16 +: 16] + 16'($urandom_range(64)) - 16'd32;
        return r;
    endfunction

    localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] TYP_PL = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] TYP_PM = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] TYP_PH = {16'd6000, 16'hC6F8, 16'd15500};

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cal_temp = '0;
        cal_low = '0;
        cal_mid = '0;
        cal_high = '0;
        send_idle = 0;
        recv_stall = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        zero_divisor_seen = 0;
        quiet_cycles = 0;
        running = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        running <= 1'b1;

        // With reset calibration the pressure divisor is zero.
        add_sample(20'd0, 20'd0);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'd519888, 20'd415148);
        drain();

        load_cal(TYP_T, TYP_PL, TYP_PM, TYP_PH);
        add_sample(20'd519888, 20'd415148);
        add_sample(20'd0, 20'd0);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'd0, 20'hFFFFF);
        add_sample(20'hFFFFF, 20'd0);
        add_sample(20'h80000, 20'h80000);
        add_sample(20'd440000, 20'd300000);
        drain();

        load_cal(CAL_MASK, CAL_MASK, CAL_MASK, CAL_MASK);
        add_sample(20'd0, 20'd0);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'h55555, 20'hAAAAA);
        drain();

        // Divisor zero with nonzero temperature calibration.
        load_cal(TYP_T, 48'd0, TYP_PM, TYP_PH);
        add_sample(20'd519888, 20'd415148);
        add_sample(20'hFFFFF, 20'd1);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            set_idling(ph);
            if (ph % 3 == 0)
                load_cal(random_cal(), random_cal(), random_cal(), random_cal());
            else
                load_cal(near_typical(TYP_T), near_typical(TYP_PL),
                         near_typical(TYP_PM), near_typical(TYP_PH));
            for (int n = 0; n < 125; n++)
            begin
                if ($urandom_range(3) == 0)
                    add_sample(20'($urandom), 20'($urandom));
                else
                    add_sample(20'($urandom_range(560000, 440000)),
                               20'($urandom_range(500000, 250000)));
            end
            drain();
        end

        running <= 1'b0;
        $display("Ran %0d sample pairs, %0d results checked, %0d with zero divisor.",
                 beats_in, beats_out, zero_divisor_seen);
        $display("Covered reset, typical, all-ones and random calibrations under four idling modes.");
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
